/* sv/sfd_pkg.sv */
`timescale 1ns / 1ps

package sfd_pkg;

	localparam int LONG_FRAME_LEN  = 4100;
	localparam int SHORT_FRAME_LEN = 32;

	localparam int POS_W = 13;

	localparam logic [2:0] KIND_ACCEL_SAMPLE = 3'd0;
	localparam logic [2:0] KIND_INCL_SAMPLE  = 3'd1;
	localparam logic [2:0] KIND_EVENT        = 3'd2;
	localparam logic [2:0] KIND_ACCEL_OK     = 3'd3;
	localparam logic [2:0] KIND_INCL_OK      = 3'd4;
	localparam logic [2:0] KIND_BAD_FOOTER   = 3'd5;
	localparam logic [2:0] KIND_UNKNOWN      = 3'd6;
	localparam logic [2:0] KIND_INCOMPLETE   = 3'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]         record_kind;
		logic signed [15:0] sample_x;
		logic signed [15:0] sample_y;
		logic signed [15:0] sample_z;
		logic [15:0]        event_id;
		logic [47:0]        start_stamp;
		logic [47:0]        end_stamp;
		logic [15:0]        temperature_raw;
		logic               ff_run_seen;
		logic               last_of_run;
	} rec_item_t;

	typedef struct packed {
		logic [1:0] count;
		rec_item_t  first;
		rec_item_t  second;
	} rec_push_t;

endpackage

/* sv/sfd_parser.sv */
`timescale 1ns / 1ps

module sfd_parser import sfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  byte_item_t byte_item,
	input  logic       room,
	output rec_push_t  push
);

	localparam logic [2:0] FT_NONE  = 3'd0;
	localparam logic [2:0] FT_EVENT = 3'd1;
	localparam logic [2:0] FT_ACCEL = 3'd2;
	localparam logic [2:0] FT_INCL  = 3'd3;
	localparam logic [2:0] FT_SKIP  = 3'd4;

	localparam logic [POS_W-1:0] POS_LAST_LONG  = POS_W'(LONG_FRAME_LEN - 1);
	localparam logic [POS_W-1:0] POS_TEMP_HI    = POS_W'(LONG_FRAME_LEN - 5);
	localparam logic [POS_W-1:0] POS_TEMP_LO    = POS_W'(LONG_FRAME_LEN - 4);
	localparam logic [POS_W-1:0] POS_LAST_SHORT = POS_W'(SHORT_FRAME_LEN - 1);
	localparam bit               SAMPLES_ON     = (LONG_FRAME_LEN >= 20);

	byte_item_t        item_s1;
	logic              valid_s1;
	logic              advance;

	logic [POS_W-1:0]  pos_q;
	logic [2:0]        ftype_q;
	logic [23:0]       recent_q;
	logic [39:0]       gather_q;
	logic [2:0]        ffc_q;
	logic              fflag_q;
	logic [15:0]       event_q;
	logic [47:0]       start_q;
	logic [47:0]       end_q;
	logic [15:0]       temp_q;
	logic [2:0]        ph6_q;

	logic [7:0]        b;
	logic [23:0]       recent_n;
	logic [39:0]       gather_n;
	logic [2:0]        ffc_n;
	logic              fflag_n;
	logic [2:0]        ft_cur;
	logic [15:0]       event_n;
	logic [47:0]       start_n;
	logic [47:0]       end_n;
	logic [15:0]       temp_n;
	logic [2:0]        ph6_n;
	logic [POS_W-1:0]  pos_n;
	logic [2:0]        ftype_n;
	logic              done;
	logic              main_hit;
	logic              inc_hit;
	logic              in_window;
	rec_item_t         main_rec;
	rec_item_t         inc_rec;

	assign advance    = valid_s1 & room;
	assign byte_stall = valid_s1 & ~room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	always_comb begin
		b        = item_s1.data_byte;
		recent_n = {recent_q[15:0], b};
		gather_n = {gather_q[31:0], b};
		event_n  = event_q;
		start_n  = start_q;
		end_n    = end_q;
		temp_n   = temp_q;
		done     = 1'b0;
		main_hit = 1'b0;
		main_rec = '0;
		inc_rec  = '0;

		if (b == 8'hFF) begin
			if (pos_q == '0) begin
				ffc_n = 3'd1;
			end else begin
				ffc_n = (ffc_q < 3'd6) ? ffc_q + 3'd1 : 3'd6;
			end
		end else begin
			ffc_n = 3'd0;
		end
		fflag_n = ((pos_q == '0) ? 1'b0 : fflag_q) | (ffc_n >= 3'd6);

		if (pos_q == POS_W'(2)) begin
			if (recent_n[23:8] == 16'hAABB) begin
				ft_cur = FT_EVENT;
			end else if (recent_n == 24'hCCDDFF) begin
				ft_cur = FT_ACCEL;
			end else if (recent_n == 24'hEEFFFF) begin
				ft_cur = FT_INCL;
			end else begin
				ft_cur = FT_SKIP;
			end
		end else if (pos_q == '0) begin
			ft_cur = FT_NONE;
		end else begin
			ft_cur = ftype_q;
		end

		if (pos_q == POS_W'(2)) begin
			ph6_n = 3'd0;
		end else begin
			ph6_n = (ph6_q == 3'd5) ? 3'd0 : ph6_q + 3'd1;
		end

		in_window = SAMPLES_ON && (pos_q >= POS_W'(3)) && (pos_q < POS_TEMP_HI);

		case (ft_cur)
			FT_EVENT: begin
				if (pos_q == POS_W'(2) || pos_q == POS_W'(3)) begin
					event_n = {event_q[7:0], b};
				end
				if (pos_q >= POS_W'(20) && pos_q <= POS_W'(25)) begin
					start_n = {start_q[39:0], b};
				end
				if (pos_q >= POS_W'(26) && pos_q <= POS_W'(31)) begin
					end_n = {end_q[39:0], b};
				end
				if (pos_q == POS_LAST_SHORT) begin
					main_hit             = 1'b1;
					main_rec.record_kind = KIND_EVENT;
					main_rec.event_id    = event_n;
					main_rec.start_stamp = start_n;
					main_rec.end_stamp   = end_n;
					done                 = 1'b1;
				end
			end
			FT_ACCEL, FT_INCL: begin
				if (in_window) begin
					if (ft_cur == FT_ACCEL && ph6_q == 3'd5) begin
						main_hit             = 1'b1;
						main_rec.record_kind = KIND_ACCEL_SAMPLE;
						main_rec.sample_x    = gather_q[39:24];
						main_rec.sample_y    = gather_q[23:8];
						main_rec.sample_z    = {gather_q[7:0], b};
					end else if (ft_cur == FT_INCL && pos_q[1:0] == 2'd2) begin
						main_hit             = 1'b1;
						main_rec.record_kind = KIND_INCL_SAMPLE;
						main_rec.sample_x    = {gather_q[15:8], gather_q[23:16]};
						main_rec.sample_y    = {b, gather_q[7:0]};
					end
				end
				if (pos_q == POS_TEMP_HI || pos_q == POS_TEMP_LO) begin
					temp_n = {temp_q[7:0], b};
				end
				if (pos_q == POS_LAST_LONG) begin
					main_hit = 1'b1;
					done     = 1'b1;
					if (ft_cur == FT_ACCEL && recent_n == 24'hFFEEFF) begin
						main_rec.record_kind     = KIND_ACCEL_OK;
						main_rec.temperature_raw = temp_n;
						main_rec.ff_run_seen     = fflag_n;
					end else if (ft_cur == FT_INCL && recent_n == 24'hFFCCDD) begin
						main_rec.record_kind = KIND_INCL_OK;
					end else begin
						main_rec.record_kind = KIND_BAD_FOOTER;
					end
				end
			end
			FT_SKIP: begin
				if (pos_q == POS_W'(2)) begin
					main_hit             = 1'b1;
					main_rec.record_kind = KIND_UNKNOWN;
				end
				if (pos_q == POS_LAST_LONG) begin
					done = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (done) begin
			pos_n   = '0;
			ftype_n = FT_NONE;
		end else begin
			pos_n   = pos_q + POS_W'(1);
			ftype_n = ft_cur;
		end

		inc_hit = item_s1.end_of_buffer && (pos_n != '0) && (ftype_n != FT_SKIP);
		if (item_s1.end_of_buffer) begin
			pos_n   = '0;
			ftype_n = FT_NONE;
		end

		inc_rec.record_kind = KIND_INCOMPLETE;
		inc_rec.last_of_run = 1'b1;
		main_rec.last_of_run = ~inc_hit;

		push = '0;
		if (advance) begin
			if (main_hit) begin
				push.first  = main_rec;
				push.second = inc_rec;
				push.count  = inc_hit ? 2'd2 : 2'd1;
			end else if (inc_hit) begin
				push.first = inc_rec;
				push.count = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			ftype_q  <= FT_NONE;
			recent_q <= '0;
			gather_q <= '0;
			ffc_q    <= '0;
			fflag_q  <= 1'b0;
			event_q  <= '0;
			start_q  <= '0;
			end_q    <= '0;
			temp_q   <= '0;
			ph6_q    <= '0;
		end else if (advance) begin
			pos_q    <= pos_n;
			ftype_q  <= ftype_n;
			recent_q <= recent_n;
			gather_q <= gather_n;
			ffc_q    <= ffc_n;
			fflag_q  <= fflag_n;
			event_q  <= event_n;
			start_q  <= start_n;
			end_q    <= end_n;
			temp_q   <= temp_n;
			ph6_q    <= ph6_n;
		end
	end

endmodule

/* sv/sfd_result_fifo.sv */
`timescale 1ns / 1ps

module sfd_result_fifo import sfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rec_push_t push,
	output logic      room,
	output logic      rec_valid,
	input  logic      rec_stall,
	output rec_item_t rec_item
);

	rec_item_t  mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic       pop;
	logic [1:0] wr_next;

	assign rec_valid = (cnt_q != 3'd0);
	assign rec_item  = mem_q[rd_q];
	assign pop       = rec_valid & ~rec_stall;
	assign room      = (cnt_q <= 3'd2);
	assign wr_next   = wr_q + 2'd1;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push.count;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.count} - {2'b00, pop};
		end
	end

endmodule

/* sv/sensor_frame_deframer_top.sv */
`timescale 1ns / 1ps

// frame deframer: one byte item is taken per clock when the record queue has room for
// two records; a byte is registered in the input stage and its records in the queue,
// the rate is set by the single record port, which drains one record per cycle unless
// stalled; a byte closing a sample at end of buffer pushes two records. no reset sweep
module sensor_frame_deframer_top import sfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  byte_item_t byte_item,
	output logic       rec_valid,
	input  logic       rec_stall,
	output rec_item_t  rec_item
);

	rec_push_t push;
	logic      room;

	sfd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.room       (room),
		.push       (push)
	);

	sfd_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_item  (rec_item)
	);

endmodule

/* sv/sfd_checker.sv */
`timescale 1ns / 1ps

module sfd_checker import sfd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       byte_stall,
	input logic       rec_valid,
	input logic       rec_stall,
	input rec_item_t  rec_item
);

	a_rec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_stall |=> rec_valid && $stable(rec_item))
		else $error("record changed while stalled");

	a_incomplete_last: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_item.record_kind == KIND_INCOMPLETE |-> rec_item.last_of_run)
		else $error("incomplete record not last of run");

	a_ff_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_item.ff_run_seen |-> rec_item.record_kind == KIND_ACCEL_OK)
		else $error("ff run flag on wrong record");

	a_event_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_item.record_kind == KIND_EVENT
		|-> rec_item.sample_x == 16'sd0 && rec_item.temperature_raw == 16'd0)
		else $error("event record carries sample data");

	a_stall_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> rec_valid)
		else $error("input stalled with empty record queue");

endmodule

bind sensor_frame_deframer_top sfd_checker u_sfd_checker (.*);

/* verif/sensor_frame_deframer_top_tb.sv */
`timescale 1ns / 1ps

module sensor_frame_deframer_top_tb;
	import sfd_pkg::*;

	localparam logic [15:0] HDR_EVENT  = 16'hAABB;
	localparam logic [23:0] HDR_ACCEL  = 24'hCCDDFF;
	localparam logic [23:0] HDR_INCL   = 24'hEEFFFF;
	localparam logic [23:0] FOOT_ACCEL = 24'hFFEEFF;
	localparam logic [23:0] FOOT_INCL  = 24'hFFCCDD;
	localparam int          RANDOM_ITEMS = 1150;

	typedef enum logic [2:0] {
		FRM_NONE,
		FRM_EVENT,
		FRM_ACCEL,
		FRM_INCL,
		FRM_SKIP
	} frame_kind_e;

	class frame_record_board;
		frame_kind_e frm;
		int          pos;
		int          ff_run;
		bit          ff_flag;
		logic [23:0] recent;
		logic [39:0] gather;
		logic [15:0] ev_word;
		logic [15:0] temp_w;
		logic [47:0] start_g;
		logic [47:0] end_g;
		rec_item_t   due_records[$];
		int          errors;

		function new();
			frm = FRM_NONE;
			pos = 0;
			ff_run = 0;
			ff_flag = 0;
			recent = '0;
			gather = '0;
			ev_word = '0;
			temp_w = '0;
			start_g = '0;
			end_g = '0;
			errors = 0;
		endfunction

		task report(string msg);
			if (errors < 200)
				$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function rec_item_t blank(logic [2:0] kind);
			rec_item_t r;
			r = '0;
			r.record_kind = kind;
			return r;
		endfunction

		function void take_byte(byte_item_t it);
			logic [7:0] b;
			int         p;
			int         q;
			bit         done;
			rec_item_t  r;
			rec_item_t  recs[$];
			b = it.data_byte;
			p = pos;
			done = 0;
			recent = {recent[15:0], b};
			if (p == 0) begin
				frm = FRM_NONE;
				ff_flag = 0;
				ff_run = (b == 8'hFF) ? 1 : 0;
			end else begin
				ff_run = (b == 8'hFF) ? ((ff_run < 6) ? ff_run + 1 : 6) : 0;
			end
			if (ff_run >= 6)
				ff_flag = 1;
			if (p == 2) begin
				if (recent[23:8] == HDR_EVENT)
					frm = FRM_EVENT;
				else if (recent == HDR_ACCEL)
					frm = FRM_ACCEL;
				else if (recent == HDR_INCL)
					frm = FRM_INCL;
				else
					frm = FRM_SKIP;
			end
			case (frm)
				FRM_EVENT: begin
					if (p == 2 || p == 3)
						ev_word = {ev_word[7:0], b};
					if (p >= 20 && p <= 25)
						start_g = {start_g[39:0], b};
					if (p >= 26 && p <= 31)
						end_g = {end_g[39:0], b};
					if (p == SHORT_FRAME_LEN - 1) begin
						r = blank(KIND_EVENT);
						r.event_id = ev_word;
						r.start_stamp = start_g;
						r.end_stamp = end_g;
						recs.push_back(r);
						done = 1;
					end
				end
				FRM_ACCEL, FRM_INCL: begin
					if (LONG_FRAME_LEN >= 20 && p >= 3 && p < LONG_FRAME_LEN - 5) begin
						q = p - 3;
						if (frm == FRM_ACCEL && q % 6 == 5) begin
							r = blank(KIND_ACCEL_SAMPLE);
							r.sample_x = gather[39:24];
							r.sample_y = gather[23:8];
							r.sample_z = {gather[7:0], b};
							recs.push_back(r);
						end else if (frm == FRM_INCL && q % 4 == 3) begin
							r = blank(KIND_INCL_SAMPLE);
							r.sample_x = {gather[15:8], gather[23:16]};
							r.sample_y = {b, gather[7:0]};
							recs.push_back(r);
						end
					end
					if (p == LONG_FRAME_LEN - 5 || p == LONG_FRAME_LEN - 4)
						temp_w = {temp_w[7:0], b};
					if (p == LONG_FRAME_LEN - 1) begin
						if (frm == FRM_ACCEL && recent == FOOT_ACCEL) begin
							r = blank(KIND_ACCEL_OK);
							r.temperature_raw = temp_w;
							r.ff_run_seen = ff_flag;
						end else if (frm == FRM_INCL && recent == FOOT_INCL) begin
							r = blank(KIND_INCL_OK);
						end else begin
							r = blank(KIND_BAD_FOOTER);
						end
						recs.push_back(r);
						done = 1;
					end
				end
				FRM_SKIP: begin
					if (p == 2)
						recs.push_back(blank(KIND_UNKNOWN));
					if (p == LONG_FRAME_LEN - 1)
						done = 1;
				end
				default: ;
			endcase
			gather = {gather[31:0], b};
			if (done) begin
				pos = 0;
				frm = FRM_NONE;
			end else begin
				pos = (p + 1) % 8192;
			end
			if (it.end_of_buffer) begin
				if (pos != 0 && frm != FRM_SKIP)
					recs.push_back(blank(KIND_INCOMPLETE));
				pos = 0;
				frm = FRM_NONE;
			end
			if (recs.size() > 0)
				recs[recs.size() - 1].last_of_run = 1'b1;
			foreach (recs[i])
				due_records.push_back(recs[i]);
		endfunction

		task check_field(string name, logic [47:0] got, logic [47:0] want);
			if (got !== want)
				report($sformatf("%s got %h want %h", name, got, want));
		endtask

		task match_record(rec_item_t got);
			rec_item_t want;
			if (due_records.size() == 0) begin
				report($sformatf("record of kind %0d with nothing pending", got.record_kind));
				return;
			end
			want = due_records.pop_front();
			check_field("record_kind", got.record_kind, want.record_kind);
			check_field("sample_x", got.sample_x, want.sample_x);
			check_field("sample_y", got.sample_y, want.sample_y);
			check_field("sample_z", got.sample_z, want.sample_z);
			check_field("event_id", got.event_id, want.event_id);
			check_field("start_stamp", got.start_stamp, want.start_stamp);
			check_field("end_stamp", got.end_stamp, want.end_stamp);
			check_field("temperature_raw", got.temperature_raw, want.temperature_raw);
			check_field("ff_run_seen", got.ff_run_seen, want.ff_run_seen);
			check_field("last_of_run", got.last_of_run, want.last_of_run);
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	byte_item_t byte_item = '0;
	logic       rec_valid;
	logic       rec_stall = 1'b0;
	rec_item_t  rec_item;

	frame_record_board board;
	logic [7:0]        frame_buf[$];
	bit                idle_mode = 1'b0;
	int                stall_left = 0;
	int                bytes_sent = 0;

	sensor_frame_deframer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item (byte_item),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_item  (rec_item)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && rec_valid && !rec_stall)
			board.match_record(rec_item);
		if (stall_left == 0 && idle_mode && $urandom_range(0, 9) == 0)
			stall_left = $urandom_range(1, 6);
		if (stall_left > 0) begin
			rec_stall <= 1'b1;
			stall_left--;
		end else begin
			rec_stall <= 1'b0;
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit eob);
		byte_item_t it;
		it.data_byte = b;
		it.end_of_buffer = eob;
		if (idle_mode && $urandom_range(0, 7) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= it;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		board.take_byte(it);
		bytes_sent++;
	endtask

	task automatic send_frame(input bit eob_last);
		for (int i = 0; i < frame_buf.size(); i++)
			send_byte(frame_buf[i], eob_last && i == frame_buf.size() - 1);
	endtask

	task automatic drain();
		byte_valid <= 1'b0;
		while (board.due_records.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] body_byte();
		return ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
	endfunction

	function automatic void build_event(logic [15:0] id, logic [47:0] t0, logic [47:0] t1);
		frame_buf.delete();
		frame_buf.push_back(HDR_EVENT[15:8]);
		frame_buf.push_back(HDR_EVENT[7:0]);
		frame_buf.push_back(id[15:8]);
		frame_buf.push_back(id[7:0]);
		for (int i = 4; i < 20; i++)
			frame_buf.push_back(body_byte());
		for (int i = 5; i >= 0; i--)
			frame_buf.push_back(t0[i * 8 +: 8]);
		for (int i = 5; i >= 0; i--)
			frame_buf.push_back(t1[i * 8 +: 8]);
	endfunction

	function automatic void build_long(logic [23:0] hdr, int len);
		frame_buf.delete();
		for (int i = 2; i >= 0; i--)
			frame_buf.push_back(hdr[i * 8 +: 8]);
		for (int i = 3; i < len; i++)
			frame_buf.push_back(body_byte());
	endfunction

	function automatic void set_tail(logic [15:0] temp, logic [23:0] foot);
		int n;
		n = frame_buf.size();
		frame_buf[n - 5] = temp[15:8];
		frame_buf[n - 4] = temp[7:0];
		frame_buf[n - 3] = foot[23:16];
		frame_buf[n - 2] = foot[15:8];
		frame_buf[n - 1] = foot[7:0];
	endfunction

	function automatic logic [47:0] rand_stamp();
		return {16'($urandom), 32'($urandom)};
	endfunction

	task automatic random_sequence();
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			build_event(16'($urandom), rand_stamp(), rand_stamp());
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(1, SHORT_FRAME_LEN - 1);
				while (frame_buf.size() > len)
					void'(frame_buf.pop_back());
				send_frame(1'b1);
			end else begin
				send_frame($urandom_range(0, 7) == 0);
			end
		end else if (pick < 60) begin
			build_long(HDR_ACCEL, $urandom_range(3, 64));
			send_frame(1'b1);
		end else if (pick < 80) begin
			build_long(HDR_INCL, $urandom_range(3, 48));
			send_frame(1'b1);
		end else if (pick < 90) begin
			build_long(24'($urandom), $urandom_range(3, 12));
			send_frame(1'b1);
		end else begin
			frame_buf.delete();
			repeat ($urandom_range(1, 3))
				frame_buf.push_back(body_byte());
			send_frame(1'b1);
		end
	endtask

	initial begin
		int rand_start;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		idle_mode = 1'b1;

		// end of buffer while the header is pending
		send_byte(8'h00, 1'b1);
		send_byte(HDR_EVENT[15:8], 1'b0);
		send_byte(HDR_EVENT[7:0], 1'b1);
		build_event(16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'h0);
		send_frame(1'b0);
		frame_buf = {8'h12, 8'h34, 8'h56};
		send_frame(1'b1);
		// sample and incomplete from the same item
		build_long(HDR_ACCEL, 3);
		frame_buf.push_back(8'h80);
		frame_buf.push_back(8'h00);
		frame_buf.push_back(8'h7F);
		frame_buf.push_back(8'hFF);
		frame_buf.push_back(8'hFF);
		frame_buf.push_back(8'hFF);
		send_frame(1'b1);
		build_long(HDR_INCL, 3);
		frame_buf.push_back(8'h00);
		frame_buf.push_back(8'h80);
		frame_buf.push_back(8'hFF);
		frame_buf.push_back(8'h7F);
		send_frame(1'b1);

		// full long frames
		build_long(HDR_ACCEL, LONG_FRAME_LEN);
		for (int i = 200; i < 206; i++)
			frame_buf[i] = 8'hFF;
		set_tail(16'hFFFF, FOOT_ACCEL);
		send_frame(1'b0);
		build_long(HDR_ACCEL, LONG_FRAME_LEN);
		set_tail(16'h0000, FOOT_INCL);
		send_frame(1'b0);
		build_long(HDR_ACCEL, LONG_FRAME_LEN);
		set_tail(16'($urandom), FOOT_ACCEL);
		send_frame(1'b1);
		build_long(HDR_INCL, LONG_FRAME_LEN);
		set_tail(16'($urandom), FOOT_INCL);
		send_frame(1'b0);
		build_long(HDR_INCL, LONG_FRAME_LEN);
		set_tail(16'($urandom), FOOT_ACCEL);
		send_frame(1'b0);
		build_long(24'hABCDEF, LONG_FRAME_LEN);
		send_frame(1'b0);
		build_event(16'($urandom), rand_stamp(), rand_stamp());
		send_frame(1'b0);

		drain();

		rand_start = bytes_sent;
		while (bytes_sent < rand_start + RANDOM_ITEMS) begin
			if (bytes_sent > rand_start + RANDOM_ITEMS - 150)
				idle_mode = 1'b0;
			else
				idle_mode = ($urandom_range(0, 3) != 0);
			random_sequence();
		end

		drain();
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("sensor_frame_deframer_top_tb passed");
		else
			$display("sensor_frame_deframer_top_tb failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("sensor_frame_deframer_top_tb failed");
		$finish;
	end

endmodule

/* files.f */
sv/sfd_pkg.sv
sv/sfd_parser.sv
sv/sfd_result_fifo.sv
sv/sensor_frame_deframer_top.sv
sv/sfd_checker.sv
verif/sensor_frame_deframer_top_tb.sv
